// File: rtl/border_region_fill_unit_assert.svh
// Assertion macros shared by the border region fill design.
`ifndef BORDER_REGION_FILL_UNIT_ASSERT_SVH
`define BORDER_REGION_FILL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, ignored while reset is high.
`define BRF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define BRF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BRF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BRF_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/brf_pkg.sv
// Shared constants and types of the border region fill design.
package brf_pkg;

   localparam int ROW_BITS_W   = 32;
   localparam int ROW_INDEX_W  = 5;
   localparam int CFG_W        = 6;
   localparam int CSR_INDEX_W  = 1;
   localparam int DEF_MAX_ROWS = 32;
   localparam int DEF_MAX_COLS = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLS = 1'b1;

   localparam logic [CFG_W-1:0] RESET_NUM_ROWS = 6'd32;
   localparam logic [CFG_W-1:0] RESET_NUM_COLS = 6'd32;

   typedef struct packed {
      logic open_we;
      logic reach_we;
      logic rd_en;
   } mem_ctl_type;

endpackage

// File: rtl/brf_ifs.sv
// Channel interfaces: input rows, result rows and register writes.
interface brf_req_if;
   logic                          valid;
   logic                          ready;
   logic [brf_pkg::ROW_BITS_W-1:0] row_bits;

   modport source (output valid, output row_bits, input ready);
   modport sink   (input valid, input row_bits, output ready);
endinterface

interface brf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [brf_pkg::ROW_BITS_W-1:0]  row_out;
   logic [brf_pkg::ROW_INDEX_W-1:0] row_index;
   logic                           last;

   modport source (output valid, output row_out, output row_index, output last, input ready);
   modport sink   (input valid, input row_out, input row_index, input last, output ready);
endinterface

interface brf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [brf_pkg::CSR_INDEX_W-1:0] index;
   logic [brf_pkg::CFG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/brf_grow_unit.sv
// Shared row unit: border seeding and one-step 4-connected growth of a row.
module brf_grow_unit #(
   parameter int ROW_W = 32
) (
   input  logic             seed_mode,
   input  logic             border_row,
   input  logic [ROW_W-1:0] col_mask,
   input  logic [ROW_W-1:0] edge_mask,
   input  logic [ROW_W-1:0] open_row,
   input  logic [ROW_W-1:0] cur_row,
   input  logic [ROW_W-1:0] prv_row,
   input  logic [ROW_W-1:0] nxt_row,
   output logic [ROW_W-1:0] grow_row,
   output logic             grew
);
   logic [ROW_W-1:0] border;
   logic [ROW_W-1:0] spread;
   logic [ROW_W-1:0] allowed;

   always_comb begin
      border  = border_row ? col_mask : edge_mask;
      allowed = open_row & col_mask;
      spread  = cur_row | (cur_row << 1) | (cur_row >> 1) | prv_row | nxt_row;
      if (seed_mode) begin
         grow_row = allowed & border;
      end else begin
         grow_row = allowed & spread;
      end
      grew = (grow_row != cur_row);
   end
endmodule

// File: rtl/brf_grid_mem.sv
// Grid storage: open-cell rows and reached-cell rows, registered reads.
module brf_grid_mem #(
   parameter int DEPTH = 32,
   parameter int ROW_W = 32,
   parameter int AW    = 5
) (
   input  logic                 clock,
   input  brf_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]        open_waddr,
   input  logic [ROW_W-1:0]     open_wdata,
   input  logic [AW-1:0]        open_raddr,
   input  logic [AW-1:0]        reach_waddr,
   input  logic [ROW_W-1:0]     reach_wdata,
   input  logic [AW-1:0]        reach_raddr_a,
   input  logic [AW-1:0]        reach_raddr_b,
   output logic [ROW_W-1:0]     open_rdata,
   output logic [ROW_W-1:0]     reach_rdata_a,
   output logic [ROW_W-1:0]     reach_rdata_b
);
   import brf_pkg::*;

   logic [ROW_W-1:0] open_mem  [DEPTH];
   logic [ROW_W-1:0] reach_mem [DEPTH];
   logic [ROW_W-1:0] open_rd_ff;
   logic [ROW_W-1:0] reach_a_ff;
   logic [ROW_W-1:0] reach_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.open_we) begin
         open_mem[open_waddr] <= open_wdata;
      end
      if (ctl.reach_we) begin
         reach_mem[reach_waddr] <= reach_wdata;
      end
      if (ctl.rd_en) begin
         open_rd_ff <= open_mem[open_raddr];
         reach_a_ff <= reach_mem[reach_raddr_a];
         reach_b_ff <= reach_mem[reach_raddr_b];
      end
   end

   assign open_rdata    = open_rd_ff;
   assign reach_rdata_a = reach_a_ff;
   assign reach_rdata_b = reach_b_ff;
endmodule

// File: rtl/brf_seq.sv
// Sequencer: row loading, seed pass, propagation sweeps and row output.
`include "border_region_fill_unit_assert.svh"

module brf_seq #(
   parameter int MAX_ROWS = 32,
   parameter int ROW_W    = 32,
   parameter int AW       = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   brf_req_if.sink               req_port,
   brf_rsp_if.source             rsp_port,
   brf_csr_if.sink               csr_port,
   output brf_pkg::mem_ctl_type  mem_ctl,
   output logic [AW-1:0]         open_waddr,
   output logic [ROW_W-1:0]      open_wdata,
   output logic [AW-1:0]         open_raddr,
   output logic [AW-1:0]         reach_waddr,
   output logic [ROW_W-1:0]      reach_wdata,
   output logic [AW-1:0]         reach_raddr_a,
   output logic [AW-1:0]         reach_raddr_b,
   input  logic [ROW_W-1:0]      open_rdata,
   input  logic [ROW_W-1:0]      reach_rdata_a,
   input  logic [ROW_W-1:0]      reach_rdata_b
);
   import brf_pkg::*;

   localparam int CW  = $clog2(MAX_ROWS + 1);
   localparam int IXW = AW + ROW_INDEX_W;

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_SEED_RD  = 3'd1;
   localparam logic [2:0] S_SEED_WR  = 3'd2;
   localparam logic [2:0] S_SWP_RD   = 3'd3;
   localparam logic [2:0] S_SWP_WR   = 3'd4;
   localparam logic [2:0] S_OUT_RD   = 3'd5;
   localparam logic [2:0] S_OUT_LD   = 3'd6;
   localparam logic [2:0] S_OUT_HOLD = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    row_ff, row_in;
   logic [CW-1:0]    loaded_ff, loaded_in;
   logic [ROW_W-1:0] prv_ff, prv_in;
   logic             changed_ff, changed_in;
   logic [CFG_W-1:0] num_rows_ff, num_cols_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [ROW_INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [6:0]       rows7, cols7, v_rows7, v_cols7;
   logic [CW-1:0]    rows_eff, rows_m1, slot_cnt, loaded_nxt, row_ext;
   logic [ROW_W-1:0] col_mask, edge_mask;
   logic             is_last, req_fire, rsp_fire, grid_done;
   logic [IXW-1:0]   idx_ext;

   logic             seed_mode;
   logic [ROW_W-1:0] nxt_row, grow_row;
   logic             grew;

   // Effective row and column counts after clamping the registers.
   always_comb begin
      v_rows7 = {1'b0, num_rows_ff};
      v_cols7 = {1'b0, num_cols_ff};
      if (v_rows7 == 7'd0) begin
         rows7 = 7'd1;
      end else if (v_rows7 > 7'(MAX_ROWS)) begin
         rows7 = 7'(MAX_ROWS);
      end else begin
         rows7 = v_rows7;
      end
      if (v_cols7 == 7'd0) begin
         cols7 = 7'd1;
      end else if (v_cols7 > 7'(ROW_W)) begin
         cols7 = 7'(ROW_W);
      end else begin
         cols7 = v_cols7;
      end
      rows_eff = CW'(rows7);
      rows_m1  = rows_eff - CW'(1);
      for (int i = 0; i < ROW_W; i++) begin
         col_mask[i]  = (7'(i) < cols7);
         edge_mask[i] = (i == 0) || (7'(i) == (cols7 - 7'd1));
      end
   end

   assign row_ext    = CW'(row_ff);
   assign is_last    = (row_ext == rows_m1);
   assign slot_cnt   = (loaded_ff >= rows_eff) ? rows_m1 : loaded_ff;
   assign loaded_nxt = slot_cnt + CW'(1);
   assign grid_done  = (loaded_nxt >= rows_eff);
   assign idx_ext    = IXW'(row_ff);

   assign req_port.ready = (state_ff == S_LOAD);
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_port.ready;
   assign csr_port.ready = 1'b1;

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.row_out   = ROW_BITS_W'(rsp_row_ff);
   assign rsp_port.row_index = rsp_idx_ff;
   assign rsp_port.last      = rsp_last_ff;

   // The row below is absent on the last row of the grid.
   assign nxt_row = is_last ? '0 : reach_rdata_b;

   brf_grow_unit #(
      .ROW_W (ROW_W)
   ) u_grow (
      .seed_mode  (seed_mode),
      .border_row ((row_ff == '0) || is_last),
      .col_mask   (col_mask),
      .edge_mask  (edge_mask),
      .open_row   (open_rdata),
      .cur_row    (reach_rdata_a),
      .prv_row    (prv_ff),
      .nxt_row    (nxt_row),
      .grow_row   (grow_row),
      .grew       (grew)
   );

   assign open_waddr    = slot_cnt[AW-1:0];
   assign open_wdata    = req_port.row_bits[ROW_W-1:0] & col_mask;
   assign open_raddr    = row_ff;
   assign reach_waddr   = row_ff;
   assign reach_wdata   = grow_row;
   assign reach_raddr_a = row_ff;
   assign reach_raddr_b = row_ff + AW'(1);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      loaded_in    = loaded_ff;
      prv_in       = prv_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      mem_ctl      = '0;
      seed_mode    = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               mem_ctl.open_we = 1'b1;
               loaded_in       = loaded_nxt;
               if (grid_done) begin
                  row_in   = '0;
                  state_in = S_SEED_RD;
               end
            end
         end
         S_SEED_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_SEED_WR;
         end
         S_SEED_WR: begin
            seed_mode        = 1'b1;
            mem_ctl.reach_we = 1'b1;
            if (is_last) begin
               row_in     = '0;
               prv_in     = '0;
               changed_in = 1'b0;
               state_in   = S_SWP_RD;
            end else begin
               row_in   = row_ff + AW'(1);
               state_in = S_SEED_RD;
            end
         end
         S_SWP_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_SWP_WR;
         end
         S_SWP_WR: begin
            mem_ctl.reach_we = 1'b1;
            prv_in           = grow_row;
            changed_in       = changed_ff || grew;
            if (is_last) begin
               row_in     = '0;
               prv_in     = '0;
               changed_in = 1'b0;
               // Another sweep only when this one grew the reached set.
               state_in   = (changed_ff || grew) ? S_SWP_RD : S_OUT_RD;
            end else begin
               row_in   = row_ff + AW'(1);
               state_in = S_SWP_RD;
            end
         end
         S_OUT_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = reach_rdata_a & col_mask;
            rsp_idx_in   = idx_ext[ROW_INDEX_W-1:0];
            rsp_last_in  = is_last;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (is_last) begin
                  loaded_in = '0;
                  row_in    = '0;
                  state_in  = S_LOAD;
               end else begin
                  row_in   = row_ff + AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         row_ff       <= '0;
         loaded_ff    <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_rows_ff  <= RESET_NUM_ROWS;
         num_cols_ff  <= RESET_NUM_COLS;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         loaded_ff    <= loaded_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_port.valid && csr_port.ready) begin
            case (csr_port.index)
               CSR_NUM_ROWS: num_rows_ff <= csr_port.data;
               CSR_NUM_COLS: num_cols_ff <= csr_port.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prv_ff      <= prv_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   `BRF_ASSERT_IMP(a_no_load_while_out, clock, reset, req_port.ready, !rsp_valid_ff, "input taken while a result is pending")
   `BRF_ASSERT_NXT(a_done_starts_seed, clock, reset, req_fire && grid_done, state_ff == S_SEED_RD, "completed grid did not start the seed pass")
   `BRF_ASSERT_IMP(a_reach_we_states, clock, reset, mem_ctl.reach_we, (state_ff == S_SEED_WR) || (state_ff == S_SWP_WR), "reached rows written outside a pass")
   `BRF_ASSERT_NXT(a_last_ends_grid, clock, reset, rsp_fire && rsp_last_ff, (state_ff == S_LOAD) && (loaded_ff == '0), "grid not closed after its last row")
endmodule

// File: rtl/border_region_fill_unit.sv
// Top level of the border region fill block: sequencer and grid storage.
//
// Rows of a binary grid arrive on req_port, one item per row, bit c = column c,
// 1 for an open cell. Ready stays high while the rows of a grid are loaded.
// After the row that completes the grid (num_rows rows, register 0), the block
// drops ready and runs a seed pass and then propagation sweeps over the rows
// stored in memory. Each pass reads a row from the registered row memories,
// then writes back the row that the shared row unit computes. Sweeps repeat
// until one grows nothing. Results leave on rsp_port, one item per row with
// its index, last set on the final row; each row is read, loaded into the
// output register and held, valid and the row staying put until ready is
// seen. Only open cells that are 4-connected to an open border cell stay
// open. Input is taken again after the last row has been delivered.
// Registers on csr_port: index 0 num_rows, index 1 num_cols; both reset to 32.
// Reset returns to loading row 0; no memory clearing pass is needed since
// every stored row is written before it is read.
module border_region_fill_unit #(
   parameter int MAX_ROWS = brf_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = brf_pkg::DEF_MAX_COLS
) (
   input  logic       clock,
   input  logic       reset,
   brf_req_if.sink    req_port,
   brf_rsp_if.source  rsp_port,
   brf_csr_if.sink    csr_port
);
   import brf_pkg::*;

   localparam int ROW_W = (MAX_COLS < ROW_BITS_W) ? MAX_COLS : ROW_BITS_W;
   localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   mem_ctl_type      mem_ctl;
   logic [AW-1:0]    open_waddr, open_raddr, reach_waddr, reach_raddr_a, reach_raddr_b;
   logic [ROW_W-1:0] open_wdata, reach_wdata, open_rdata, reach_rdata_a, reach_rdata_b;

   brf_seq #(
      .MAX_ROWS (MAX_ROWS),
      .ROW_W    (ROW_W),
      .AW       (AW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_port      (req_port),
      .rsp_port      (rsp_port),
      .csr_port      (csr_port),
      .mem_ctl       (mem_ctl),
      .open_waddr    (open_waddr),
      .open_wdata    (open_wdata),
      .open_raddr    (open_raddr),
      .reach_waddr   (reach_waddr),
      .reach_wdata   (reach_wdata),
      .reach_raddr_a (reach_raddr_a),
      .reach_raddr_b (reach_raddr_b),
      .open_rdata    (open_rdata),
      .reach_rdata_a (reach_rdata_a),
      .reach_rdata_b (reach_rdata_b)
   );

   brf_grid_mem #(
      .DEPTH (MAX_ROWS),
      .ROW_W (ROW_W),
      .AW    (AW)
   ) u_mem (
      .clock         (clock),
      .ctl           (mem_ctl),
      .open_waddr    (open_waddr),
      .open_wdata    (open_wdata),
      .open_raddr    (open_raddr),
      .reach_waddr   (reach_waddr),
      .reach_wdata   (reach_wdata),
      .reach_raddr_a (reach_raddr_a),
      .reach_raddr_b (reach_raddr_b),
      .open_rdata    (open_rdata),
      .reach_rdata_a (reach_rdata_a),
      .reach_rdata_b (reach_rdata_b)
   );
endmodule

// File: tb/sv/tb.sv
// Testbench for border_region_fill_unit: random and directed grids checked against a predictor.
module tb;
   import brf_pkg::*;

   typedef struct packed {
      logic [ROW_BITS_W-1:0]  row_out;
      logic [ROW_INDEX_W-1:0] row_index;
      logic                   last_row;
   } filled_row_type;

   // Mirrors the block: registers, stored rows, and the filled rows still owed.
   class grid_fill_board_type;
      logic [CFG_W-1:0]      num_rows;
      logic [CFG_W-1:0]      num_cols;
      logic [ROW_BITS_W-1:0] open_rows [DEF_MAX_ROWS];
      int                    rows_loaded;
      filled_row_type        expected_rows [$];
      int                    errors;
      int                    checked;
      int                    grids;

      function new();
         num_rows    = RESET_NUM_ROWS;
         num_cols    = RESET_NUM_COLS;
         rows_loaded = 0;
         errors      = 0;
         checked     = 0;
         grids       = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_NUM_ROWS) begin
            num_rows = value;
         end else if (index == CSR_NUM_COLS) begin
            num_cols = value;
         end
      endfunction

      function int used_rows();
         int n;
         n = int'(num_rows);
         if (n == 0) n = 1;
         if (n > DEF_MAX_ROWS) n = DEF_MAX_ROWS;
         return n;
      endfunction

      function int used_cols();
         int n;
         n = int'(num_cols);
         if (n == 0) n = 1;
         if (n > DEF_MAX_COLS) n = DEF_MAX_COLS;
         if (n > ROW_BITS_W) n = ROW_BITS_W;
         return n;
      endfunction

      function logic [ROW_BITS_W-1:0] col_mask(int cols);
         return (cols >= ROW_BITS_W) ? '1 : ((32'd1 << cols) - 32'd1);
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      // Seeds from the border, then grows until nothing changes; queues one row per grid row.
      function void fill_rows(int rows, int cols);
         logic [ROW_BITS_W-1:0] cm;
         logic [ROW_BITS_W-1:0] side;
         logic [ROW_BITS_W-1:0] grow;
         logic [ROW_BITS_W-1:0] reached [DEF_MAX_ROWS];
         filled_row_type        one;
         bit                    changed;
         cm   = col_mask(cols);
         side = 32'd1 | (32'd1 << (cols - 1));
         for (int r = 0; r < rows; r++) begin
            reached[r] = open_rows[r] & ((r == 0 || r == rows - 1) ? cm : side) & cm;
         end
         do begin
            changed = 1'b0;
            for (int r = 0; r < rows; r++) begin
               grow = reached[r] | (reached[r] << 1) | (reached[r] >> 1);
               if (r > 0) grow |= reached[r-1];
               if (r + 1 < rows) grow |= reached[r+1];
               grow &= open_rows[r] & cm;
               if (grow != reached[r]) begin
                  reached[r] = grow;
                  changed    = 1'b1;
               end
            end
         end while (changed);
         for (int r = 0; r < rows; r++) begin
            one.row_out   = reached[r];
            one.row_index = ROW_INDEX_W'(r);
            one.last_row  = (r == rows - 1);
            expected_rows.push_back(one);
         end
      endfunction

      function void note_row(logic [ROW_BITS_W-1:0] bits);
         int rows;
         int cols;
         int slot;
         rows = used_rows();
         cols = used_cols();
         slot = rows_loaded;
         // A row count lowered below the rows already held lands on the last slot.
         if (slot >= rows) slot = rows - 1;
         open_rows[slot] = bits & col_mask(cols);
         rows_loaded = slot + 1;
         if (rows_loaded < rows) return;
         fill_rows(rows, cols);
         rows_loaded = 0;
         grids++;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      task compare_row(logic [ROW_BITS_W-1:0] row_out, logic [ROW_INDEX_W-1:0] row_index,
                       logic last_row);
         filled_row_type want;
         if (expected_rows.size() == 0) begin
            report($sformatf("row %0d (%h) arrived with nothing expected", row_index, row_out));
            return;
         end
         want = expected_rows.pop_front();
         checked++;
         if (row_out !== want.row_out)
            report($sformatf("row %0d: row_out %h, expected %h", want.row_index, row_out,
                             want.row_out));
         if (row_index !== want.row_index)
            report($sformatf("row_index %0d, expected %0d", row_index, want.row_index));
         if (last_row !== want.last_row)
            report($sformatf("row %0d: last %b, expected %b", want.row_index, last_row,
                             want.last_row));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   brf_req_if req_if ();
   brf_rsp_if rsp_if ();
   brf_csr_if csr_if ();

   border_region_fill_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   grid_fill_board_type board;
   int send_idle_pct;
   int rsp_stall_pct;
   int hold_request;
   int items_sent;

   always #5 clock = ~clock;

   initial begin
      #30_000_000;
      $display("Timed out with %0d filled rows still owed.", board.pending());
      $display("CHECKS FAILED");
      $finish;
   end

   // Result receiver: random stalls, plus a long hold-off when one is requested.
   initial begin : receiver
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.compare_row(rsp_if.row_out, rsp_if.row_index, rsp_if.last);
   end

   // All driving tasks start and end at a falling edge.
   task automatic send_row(logic [ROW_BITS_W-1:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid    = 1'b0;
         req_if.row_bits = $urandom;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.row_bits = bits;
      do @(posedge clock); while (!req_if.ready);
      board.note_row(bits);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
      csr_if.valid = 1'b1;
      csr_if.index = index;
      csr_if.data  = value;
      do @(posedge clock); while (!csr_if.ready);
      board.set_reg(index, value);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_grid_size(int rows, int cols);
      wait_drained();
      write_reg(CSR_NUM_ROWS, CFG_W'(rows));
      write_reg(CSR_NUM_COLS, CFG_W'(cols));
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
         default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
      endcase
   endtask

   // Row contents of several densities, and a serpentine maze that needs many sweeps.
   function automatic logic [ROW_BITS_W-1:0] pattern_row(int style, int r, int cols);
      logic [ROW_BITS_W-1:0] interior;
      interior = 32'hFFFF_FFFE & ~(32'd1 << (cols - 1));
      case (style)
         0: return $urandom;
         1: return $urandom | $urandom;
         2: return $urandom & $urandom;
         3: return $urandom | $urandom | $urandom;
         default: return (r % 2 == 0) ? interior : (32'd1 << $urandom_range(cols - 1));
      endcase
   endfunction

   task automatic send_grid(int style);
      int rows;
      int cols;
      rows = board.used_rows();
      cols = board.used_cols();
      for (int r = 0; r < rows; r++) send_row(pattern_row(style, r, cols));
   endtask

   initial begin : stimulus
      int rows_plan [10];
      int cols_plan [10];
      int phase;
      int phase_start;
      rows_plan = '{4, 32, 1, 9, 0, 63, 6, 3, 12, 5};
      cols_plan = '{32, 32, 63, 1, 32, 32, 0, 8, 20, 2};
      board           = new();
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.row_bits = '0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_NUM_ROWS;
      csr_if.data     = '0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      hold_request    = 0;
      items_sent      = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Zero counts act as a single cell.
      set_grid_size(0, 0);
      send_row(32'hFFFF_FFFF);
      send_row(32'h0000_0000);
      send_row(32'hFFFF_FFFE);

      // An enclosed ring is not reached and reads back empty; bits above the columns are ignored.
      set_grid_size(5, 5);
      send_row(32'hFFFF_FFE0);
      send_row(32'hFFFF_FFEE);
      send_row(32'hA5A5_A5EA);
      send_row(32'hFFFF_FFEE);
      send_row(32'h5A5A_5A40);

      // Row count lowered while a grid is partly loaded, four of its six rows in.
      set_grid_size(6, 32);
      for (int i = 0; i < 4; i++) send_row($urandom);
      wait_drained();
      write_reg(CSR_NUM_ROWS, CFG_W'(2));
      send_row($urandom);

      // One row: every cell lies on the border.
      set_grid_size(1, 32);
      send_row(32'hFFFF_FFFF);
      send_row(32'h8000_0001);
      send_row(32'h7FFF_FFFE);
      send_row(32'h0000_0000);

      set_grid_size(3, 1);
      send_row(32'h0000_0001);
      send_row(32'hFFFF_FFFE);
      send_row(32'h0000_0001);

      phase = 0;
      while (items_sent < 230) begin
         if (phase < 10) begin
            set_grid_size(rows_plan[phase], cols_plan[phase]);
         end else begin
            set_grid_size($urandom_range(12, 2), $urandom_range(63));
         end
         set_idling(phase % 4);
         // Stall the receiver long enough for the block to back up onto its input.
         if (phase == 0) hold_request = 400;
         phase_start = items_sent;
         while (items_sent - phase_start < 24) send_grid($urandom_range(4));
         phase++;
      end

      wait_drained();
      repeat (40) @(negedge clock);
      $display("Run covered %0d input rows in %0d grids; %0d filled rows compared.",
               items_sent, board.grids, board.checked);
      $display("Row and column counts swept from zero to the 6-bit maximum, four idling mixes.");
      if (board.errors == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/brf_pkg.sv
rtl/brf_ifs.sv
rtl/brf_grow_unit.sv
rtl/brf_grid_mem.sv
rtl/brf_seq.sv
rtl/border_region_fill_unit.sv
tb/sv/tb.sv
